/* hw/rtl/pidl_pkg.sv */
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared types and constants of the PID controller with limits: register
// indexes, mode flag bits and the structs passed between the datapath parts.
// ----------------------------------------------------------------------------
package pidl_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_KP_GAIN       = 3'd0;
    localparam logic [2:0] REG_KI_GAIN       = 3'd1;
    localparam logic [2:0] REG_KD_GAIN       = 3'd2;
    localparam logic [2:0] REG_ERROR_LIMIT   = 3'd3;
    localparam logic [2:0] REG_SEP_THRESHOLD = 3'd4;
    localparam logic [2:0] REG_INT_LIMIT     = 3'd5;
    localparam logic [2:0] REG_OUTPUT_LIMIT  = 3'd6;
    localparam logic [2:0] REG_ENABLE_FLAGS  = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 31;

    // mode flag bits
    localparam int FLAG_ERR_CLAMP  = 0;
    localparam int FLAG_SEPARATION = 1;
    localparam int FLAG_INT_CLAMP  = 2;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int ERR_W    = 17;
    localparam int DIFF_W   = 18;
    localparam int INT_W    = 32;
    localparam int OUT_W    = 16;

    // register file contents
    typedef struct packed {
        logic [15:0] kp_gain;
        logic [15:0] ki_gain;
        logic [15:0] kd_gain;
        logic [15:0] error_limit;
        logic [15:0] separation_threshold;
        logic [30:0] integral_limit;
        logic [14:0] output_limit;
        logic [2:0]  enable_flags;
    } pidl_cfg_t;

    // error stage results, consumed by the control law
    typedef struct packed {
        logic [ERR_W-1:0]  err;        // clamped error, signed
        logic [DIFF_W-1:0] diff;       // err minus previous err, signed
        logic              integrate;  // integral may accumulate this item
    } pidl_err_t;

endpackage

/* hw/rtl/pid_controller_with_limits.sv */
// ----------------------------------------------------------------------------
// pid_controller_with_limits
// PID controller with error clamp, integral separation and integral and
// output limits; one drive value item for every sample item.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata fields (low bit up)          | tuser / tlast
//  s_axis   | in  | setpoint[15:0], feedback[31:16]    | none
//  m_axis   | out | drive value[15:0]                  | none
//  cfg      | in  | cfg_we, cfg_index[2:0], cfg_wdata  | write only
//
//  An item is held in the input register and then lands in the output
//  register; throughput is one item per cycle while the output is not stalled.
//  The integral and previous error update as an item moves to the output.
//  A stalled output holds its item; the input register still takes one more.
//  Synchronous active-low reset clears the state, register file and valid flags.
// ----------------------------------------------------------------------------
module pid_controller_with_limits #(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // sample items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,   // setpoint, feedback
    // drive value items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,   // drive value
    // register writes
    input  logic                                cfg_we,
    input  logic [pidl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pidl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    pidl_pkg::pidl_cfg_t                cfg_reg;
    logic                               in_valid_reg;
    logic [pidl_pkg::SAMPLE_W-1:0]      setpoint_reg;
    logic [pidl_pkg::SAMPLE_W-1:0]      feedback_reg;
    logic                               out_valid_reg;
    logic [pidl_pkg::OUT_W-1:0]         out_data_reg;
    logic [pidl_pkg::ERR_W-1:0]         prev_error_reg;
    logic [pidl_pkg::INT_W-1:0]         integral_reg;
    logic [pidl_pkg::INT_W-1:0]         integral_next;
    logic [pidl_pkg::OUT_W-1:0]         drive_out;
    pidl_pkg::pidl_err_t                err_info;
    logic                               advance;
    logic                               step;

    // handshake
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pidl_pkg::REG_KP_GAIN:       cfg_reg.kp_gain <= cfg_wdata[15:0];
                pidl_pkg::REG_KI_GAIN:       cfg_reg.ki_gain <= cfg_wdata[15:0];
                pidl_pkg::REG_KD_GAIN:       cfg_reg.kd_gain <= cfg_wdata[15:0];
                pidl_pkg::REG_ERROR_LIMIT:   cfg_reg.error_limit <= cfg_wdata[15:0];
                pidl_pkg::REG_SEP_THRESHOLD: begin
                    cfg_reg.separation_threshold <= cfg_wdata[15:0];
                end
                pidl_pkg::REG_INT_LIMIT:     cfg_reg.integral_limit <= cfg_wdata[30:0];
                pidl_pkg::REG_OUTPUT_LIMIT:  cfg_reg.output_limit <= cfg_wdata[14:0];
                pidl_pkg::REG_ENABLE_FLAGS:  cfg_reg.enable_flags <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            setpoint_reg <= s_tdata[15:0];
            feedback_reg <= s_tdata[31:16];
        end
    end

    // error path and control law
    pidl_error u_error (
        .setpoint   (setpoint_reg),
        .feedback   (feedback_reg),
        .prev_error (prev_error_reg),
        .cfg        (cfg_reg),
        .err_info   (err_info)
    );

    pidl_law #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_law (
        .err_info       (err_info),
        .integral       (integral_reg),
        .cfg            (cfg_reg),
        .integral_next  (integral_next),
        .drive_out      (drive_out)
    );

    // controller state, updated once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_error_reg <= '0;
            integral_reg   <= '0;
        end else if (step) begin
            prev_error_reg <= err_info.err;
            integral_reg   <= integral_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= drive_out;
        end
    end

`ifndef SYNTHESIS
    // output limit is at most 32767, so the most negative code never shows
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata != 16'h8000))
        else $error("drive value outside symmetric range");

    // state moves only when an item passes to the output
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> ($stable(integral_reg) && $stable(prev_error_reg)))
        else $error("controller state changed without an item");

    // input is refused only when both registers are full and output stalls
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && m_tvalid && !m_tready))
        else $error("input refused while there was room");
`endif

endmodule

/* hw/rtl/pidl_error.sv */
// ----------------------------------------------------------------------------
// pidl_error
// Error path: setpoint minus feedback, optional symmetric clamp, integral
// separation decision and the error difference for the derivative term.
// ----------------------------------------------------------------------------
module pidl_error (
    input  logic [pidl_pkg::SAMPLE_W-1:0] setpoint,
    input  logic [pidl_pkg::SAMPLE_W-1:0] feedback,
    input  logic [pidl_pkg::ERR_W-1:0]    prev_error,
    input  pidl_pkg::pidl_cfg_t           cfg,
    output pidl_pkg::pidl_err_t           err_info
);

    logic signed [pidl_pkg::DIFF_W-1:0] raw_err;
    logic signed [pidl_pkg::DIFF_W-1:0] lim_pos;
    logic signed [pidl_pkg::DIFF_W-1:0] lim_neg;
    logic signed [pidl_pkg::DIFF_W-1:0] clamped;
    logic signed [pidl_pkg::ERR_W-1:0]  err;
    logic        [pidl_pkg::ERR_W-1:0]  mag;

    // raw error, one bit wider than needed so the clamp compare cannot wrap
    assign raw_err = $signed({{2{setpoint[15]}}, setpoint})
                   - $signed({{2{feedback[15]}}, feedback});
    assign lim_pos = $signed({2'b00, cfg.error_limit});
    assign lim_neg = -lim_pos;

    // optional symmetric error clamp
    always_comb begin
        clamped = raw_err;
        if (cfg.enable_flags[pidl_pkg::FLAG_ERR_CLAMP]) begin
            if (raw_err > lim_pos) begin
                clamped = lim_pos;
            end else if (raw_err < lim_neg) begin
                clamped = lim_neg;
            end
        end
    end

    assign err = clamped[pidl_pkg::ERR_W-1:0];
    assign mag = err[pidl_pkg::ERR_W-1] ? pidl_pkg::ERR_W'(-err) : err;

    // integral separation and derivative difference
    assign err_info.err       = err;
    assign err_info.integrate = !cfg.enable_flags[pidl_pkg::FLAG_SEPARATION]
                              || (mag <= {1'b0, cfg.separation_threshold});
    assign err_info.diff      = $signed({err[pidl_pkg::ERR_W-1], err})
                              - $signed({prev_error[pidl_pkg::ERR_W-1], prev_error});

endmodule

/* hw/rtl/pidl_law.sv */
// ----------------------------------------------------------------------------
// pidl_law
// Control law: three gain products scaled by the fraction bits, saturating
// integral with optional clamp, and the clamped output sum.
// ----------------------------------------------------------------------------
module pidl_law #(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  pidl_pkg::pidl_err_t        err_info,
    input  logic [pidl_pkg::INT_W-1:0] integral,
    input  pidl_pkg::pidl_cfg_t        cfg,
    output logic [pidl_pkg::INT_W-1:0] integral_next,
    output logic [pidl_pkg::OUT_W-1:0] drive_out
);

    localparam int PK_W  = 33;   // 16 x 17 product
    localparam int PD_W  = 34;   // 16 x 18 product
    localparam int ACC_W = 34;
    localparam int Y_W   = 36;

    logic signed [PK_W-1:0]  prod_kp;
    logic signed [PK_W-1:0]  prod_ki;
    logic signed [PD_W-1:0]  prod_kd;
    logic signed [PK_W-1:0]  kp_term;
    logic signed [PK_W-1:0]  ki_term;
    logic signed [PD_W-1:0]  kd_term;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] int_base;
    logic signed [ACC_W-1:0] int_lim_pos;
    logic signed [ACC_W-1:0] int_lim_neg;
    logic signed [ACC_W-1:0] int_clamped;
    logic signed [Y_W-1:0]   y_sum;
    logic signed [Y_W-1:0]   out_lim_pos;
    logic signed [Y_W-1:0]   out_lim_neg;
    logic signed [Y_W-1:0]   y_clamped;

    // gain products, floor-scaled by an arithmetic shift
    assign prod_kp = $signed(cfg.kp_gain) * $signed(err_info.err);
    assign prod_ki = $signed(cfg.ki_gain) * $signed(err_info.err);
    assign prod_kd = $signed(cfg.kd_gain) * $signed(err_info.diff);
    assign kp_term = prod_kp >>> GAIN_FRAC_BITS;
    assign ki_term = prod_ki >>> GAIN_FRAC_BITS;
    assign kd_term = prod_kd >>> GAIN_FRAC_BITS;

    // integral accumulate with 32-bit saturation
    assign acc = $signed({{2{integral[pidl_pkg::INT_W-1]}}, integral})
               + $signed({ki_term[PK_W-1], ki_term});

    always_comb begin
        int_base = $signed({{2{integral[pidl_pkg::INT_W-1]}}, integral});
        if (err_info.integrate) begin
            if (acc > $signed(ACC_W'(34'sh0_7FFF_FFFF))) begin
                int_base = $signed(ACC_W'(34'sh0_7FFF_FFFF));
            end else if (acc < $signed(34'sh3_8000_0000)) begin
                int_base = $signed(34'sh3_8000_0000);
            end else begin
                int_base = acc;
            end
        end
    end

    // optional integral clamp
    assign int_lim_pos = $signed({3'b000, cfg.integral_limit});
    assign int_lim_neg = -int_lim_pos;

    always_comb begin
        int_clamped = int_base;
        if (cfg.enable_flags[pidl_pkg::FLAG_INT_CLAMP]) begin
            if (int_base > int_lim_pos) begin
                int_clamped = int_lim_pos;
            end else if (int_base < int_lim_neg) begin
                int_clamped = int_lim_neg;
            end
        end
    end

    assign integral_next = int_clamped[pidl_pkg::INT_W-1:0];

    // output sum and clamp
    assign y_sum = $signed({{(Y_W-PK_W){kp_term[PK_W-1]}}, kp_term})
                 + $signed({{(Y_W-pidl_pkg::INT_W){integral_next[pidl_pkg::INT_W-1]}},
                            integral_next})
                 + $signed({{(Y_W-PD_W){kd_term[PD_W-1]}}, kd_term});
    assign out_lim_pos = $signed({21'd0, cfg.output_limit});
    assign out_lim_neg = -out_lim_pos;

    always_comb begin
        y_clamped = y_sum;
        if (y_sum > out_lim_pos) begin
            y_clamped = out_lim_pos;
        end else if (y_sum < out_lim_neg) begin
            y_clamped = out_lim_neg;
        end
    end

    assign drive_out = y_clamped[pidl_pkg::OUT_W-1:0];

endmodule

/* tb/pid_controller_with_limits_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_with_limits_test
// Drives setpoint/feedback items into the PID controller and checks each
// drive value against an in-bench PID model. Covers error clamp, integral
// separation, integral and output limits, integral saturation, bursty input,
// random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module pid_controller_with_limits_test;

    localparam int FRAC_BITS    = 8;
    localparam int LATENCY      = 2;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PRINT_LIMIT  = 50;
    localparam longint SUM_MAX  = 64'sd2147483647;
    localparam longint SUM_MIN  = -SUM_MAX - 1;

    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [31:0]                       s_tdata   = '0;   // setpoint[15:0], feedback[31:16]
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [15:0]                       m_tdata;          // drive value[15:0]
    logic                              cfg_we    = 1'b0;
    logic [pidl_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [pidl_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;

    // controller settings as last written
    longint      kp_q = 0, ki_q = 0, kd_q = 0;
    longint      err_bound = 0, sep_bound = 0, int_bound = 0, out_bound = 0;
    logic [2:0]  mode_bits = '0;

    // controller state
    longint      err_hist = 0;
    longint      integ_acc = 0;

    logic [15:0] expected_outputs[$];
    int          error_count     = 0;
    int          items_sent      = 0;
    int          results_checked = 0;
    int          settings_count  = 0;
    int          burst_left      = 0;
    int          idle_cycles     = 0;

    // output side stall control
    bit          hold_request = 1'b0;
    int          hold_left    = 0;
    int          rx_tick      = 0;
    logic [15:0] stall_bits   = 16'hFFFF;

    pid_controller_with_limits #(
        .GAIN_FRAC_BITS(FRAC_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint clamp_mag(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // one control step: updates integral and last error, returns the output
    function automatic logic [15:0] predict_control(input logic signed [15:0] sp,
                                                    input logic signed [15:0] fb);
        longint e;
        longint mag;
        longint y;
        bit     take;
        e = longint'(sp) - longint'(fb);
        if (mode_bits[pidl_pkg::FLAG_ERR_CLAMP]) e = clamp_mag(e, err_bound);
        mag = (e < 0) ? -e : e;
        take = mode_bits[pidl_pkg::FLAG_SEPARATION] ? (mag <= sep_bound) : 1'b1;
        if (take) begin
            integ_acc = integ_acc + ((ki_q * e) >>> FRAC_BITS);
            if (integ_acc > SUM_MAX) integ_acc = SUM_MAX;
            if (integ_acc < SUM_MIN) integ_acc = SUM_MIN;
        end
        if (mode_bits[pidl_pkg::FLAG_INT_CLAMP]) integ_acc = clamp_mag(integ_acc, int_bound);
        y = ((kp_q * e) >>> FRAC_BITS) + integ_acc
            + ((kd_q * (e - err_hist)) >>> FRAC_BITS);
        y = clamp_mag(y, out_bound);
        err_hist = e;
        return y[15:0];
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT) $display("[%0t] error: %s", $time, msg);
        error_count++;
    endtask

    // register write; cfg_we stays high until the caller drops it
    task automatic write_reg(input logic [pidl_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [pidl_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            pidl_pkg::REG_KP_GAIN:       kp_q = longint'($signed(val[15:0]));
            pidl_pkg::REG_KI_GAIN:       ki_q = longint'($signed(val[15:0]));
            pidl_pkg::REG_KD_GAIN:       kd_q = longint'($signed(val[15:0]));
            pidl_pkg::REG_ERROR_LIMIT:   err_bound = longint'(val[15:0]);
            pidl_pkg::REG_SEP_THRESHOLD: sep_bound = longint'(val[15:0]);
            pidl_pkg::REG_INT_LIMIT:     int_bound = longint'(val[30:0]);
            pidl_pkg::REG_OUTPUT_LIMIT:  out_bound = longint'(val[14:0]);
            pidl_pkg::REG_ENABLE_FLAGS:  mode_bits = val[2:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] kp, input logic [15:0] ki,
                                  input logic [15:0] kd, input logic [15:0] el,
                                  input logic [15:0] st, input logic [30:0] il,
                                  input logic [14:0] ol, input logic [2:0] fl);
        write_reg(pidl_pkg::REG_KP_GAIN,       pidl_pkg::CFG_DATA_W'(kp));
        write_reg(pidl_pkg::REG_KI_GAIN,       pidl_pkg::CFG_DATA_W'(ki));
        write_reg(pidl_pkg::REG_KD_GAIN,       pidl_pkg::CFG_DATA_W'(kd));
        write_reg(pidl_pkg::REG_ERROR_LIMIT,   pidl_pkg::CFG_DATA_W'(el));
        write_reg(pidl_pkg::REG_SEP_THRESHOLD, pidl_pkg::CFG_DATA_W'(st));
        write_reg(pidl_pkg::REG_INT_LIMIT,     pidl_pkg::CFG_DATA_W'(il));
        write_reg(pidl_pkg::REG_OUTPUT_LIMIT,  pidl_pkg::CFG_DATA_W'(ol));
        write_reg(pidl_pkg::REG_ENABLE_FLAGS,  pidl_pkg::CFG_DATA_W'(fl));
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    // offer one sample item, bursts of random length with random gaps
    task automatic send_sample(input logic signed [15:0] sp,
                               input logic signed [15:0] fb);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {fb, sp};
        do @(posedge aclk); while (!s_tready);
        expected_outputs.push_back(predict_control(sp, fb));
        items_sent++;
    endtask

    // stop offering and wait for every output of the phase
    task automatic finish_phase;
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_outputs.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    // sample pair whose error lands near the thresholds or anywhere at all
    task automatic pick_pair(output logic signed [15:0] sp,
                             output logic signed [15:0] fb);
        longint e, lo, hi, f;
        int     r;
        r = $urandom_range(0, 4);
        if (r <= 1) begin
            sp = 16'($urandom);
            fb = 16'($urandom);
        end else begin
            if (r == 2) begin
                r = $urandom_range(0, 4);
                e = sep_bound + r - 2;
            end else if (r == 3) begin
                r = $urandom_range(0, 4);
                e = err_bound + r - 2;
            end else begin
                r = $urandom_range(0, 600);
                e = r - 300;
            end
            if ($urandom_range(0, 1)) e = -e;
            if (e > 65535) e = 65535;
            if (e < -65535) e = -65535;
            lo = (-32768 - e > -32768) ? -32768 - e : -32768;
            hi = (32767 - e < 32767) ? 32767 - e : 32767;
            f = lo + $urandom_range(0, int'(hi - lo));
            fb = f[15:0];
            sp = 16'(f + e);
        end
    endtask

    function automatic logic [15:0] pick_gain();
        int g;
        case ($urandom_range(0, 3))
            0: g = $urandom;
            1: g = $urandom_range(0, 1024) - 512;
            2: g = $urandom_range(0, 1) ? 32767 : -32768;
            default: g = 256;
        endcase
        return g[15:0];
    endfunction

    function automatic logic [15:0] pick_bound16();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 600));
            2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(0, 5000));
        endcase
    endfunction

    task automatic random_settings(input logic [2:0] fl);
        logic [30:0] il;
        logic [14:0] ol;
        case ($urandom_range(0, 3))
            0: il = 31'($urandom);
            1: il = 31'($urandom_range(0, 100000));
            2: il = 31'h7FFF_FFFF;
            default: il = 31'($urandom_range(0, 40000));
        endcase
        case ($urandom_range(0, 5))
            0: ol = 15'h7FFF;
            1: ol = 15'($urandom_range(0, 2000));
            2: ol = ($urandom_range(0, 3) == 0) ? 15'd0 : 15'h7FFF;
            default: ol = 15'($urandom);
        endcase
        apply_settings(pick_gain(), pick_gain(), pick_gain(), pick_bound16(),
                       pick_bound16(), il, ol, fl);
    endtask

    // all settings zero after reset, so every output is zero
    task automatic test_reset_state;
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sd0, 16'sd0);
        finish_phase();
    endtask

    // smallest gain shows floor rounding; full-scale errors both ways
    task automatic test_scaling_and_extremes;
        apply_settings(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 31'd0, 15'h7FFF, 3'b000);
        send_sample(16'sd0, 16'sd1);
        send_sample(16'sd1, 16'sd0);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh7FFF, 16'sh8000);
        finish_phase();
    endtask

    // error clamp, separation boundary and integral clamp together
    task automatic test_limit_modes;
        apply_settings(16'd256, 16'd256, 16'd256, 16'd100, 16'd50, 31'd1000,
                       15'h7FFF, 3'b111);
        send_sample(16'sd300, 16'sd0);
        send_sample(16'sd40, 16'sd0);
        send_sample(16'sd0, 16'sd40);
        send_sample(16'sd50, 16'sd0);
        send_sample(16'sd51, 16'sd0);
        send_sample(16'sd0, 16'sd51);
        send_sample(-16'sd150, 16'sd150);
        finish_phase();
    endtask

    // zero bounds force error, integral and then output to zero
    task automatic test_zero_limits;
        apply_settings(16'd256, 16'd256, 16'd256, 16'd0, 16'd0, 31'd0,
                       15'h7FFF, 3'b101);
        send_sample(16'sd1000, 16'sd0);
        send_sample(16'sd0, -16'sd1000);
        finish_phase();
        apply_settings(16'd256, 16'd256, 16'd256, 16'd0, 16'd0, 31'd0,
                       15'd0, 3'b000);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);
        finish_phase();
    endtask

    // extreme gains with widest bounds, derivative swinging full scale
    task automatic test_full_scale_gains;
        apply_settings(16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF,
                       31'h7FFF_FFFF, 15'h7FFF, 3'b111);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sd0, 16'sd0);
        finish_phase();
    endtask

    // drive the integral into the upper bound, then all the way down
    task automatic test_integral_windup;
        logic signed [15:0] sp, fb;
        apply_settings(16'd0, 16'h7FFF, 16'd0, 16'd0, 16'd0, 31'd0, 15'h7FFF, 3'b000);
        for (int i = 0; i < 300; i++) begin
            sp = 16'(30000 + int'($urandom_range(0, 2767)));
            fb = 16'(-32768 + int'($urandom_range(0, 2768)));
            send_sample(sp, fb);
        end
        for (int i = 0; i < 600; i++) begin
            sp = 16'(-32768 + int'($urandom_range(0, 2768)));
            fb = 16'(30000 + int'($urandom_range(0, 2767)));
            send_sample(sp, fb);
        end
        finish_phase();
    endtask

    // long output hold-off while input keeps coming
    task automatic test_output_backpressure;
        logic signed [15:0] sp, fb;
        random_settings(3'($urandom_range(0, 7)));
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++) begin
            pick_pair(sp, fb);
            send_sample(sp, fb);
        end
        finish_phase();
    endtask

    // one phase per mode combination with random settings and samples
    task automatic test_random_phases;
        logic signed [15:0] sp, fb;
        for (int ph = 0; ph < 8; ph++) begin
            random_settings(3'(ph));
            for (int i = 0; i < 125; i++) begin
                pick_pair(sp, fb);
                send_sample(sp, fb);
            end
            finish_phase();
        end
    endtask

    // output stalls: rotating random pattern, all-ready stretches, hold-off
    always @(posedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (rx_tick == 0) begin
            stall_bits = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            if (stall_bits == 16'h0000) stall_bits = 16'hFFFF;
        end
        rx_tick = (rx_tick + 1) % 64;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= stall_bits[rx_tick % 16];
        end
    end

    // compare each output item with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_outputs.size() == 0) begin
                report_mismatch($sformatf("unexpected drive value %h", m_tdata));
            end else begin
                if (m_tdata !== expected_outputs[0])
                    report_mismatch($sformatf("drive value got %h want %h",
                                              m_tdata, expected_outputs[0]));
                void'(expected_outputs.pop_front());
                results_checked++;
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("no progress for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_scaling_and_extremes();
        test_limit_modes();
        test_zero_limits();
        test_full_scale_gains();
        test_integral_windup();
        test_output_backpressure();
        test_random_phases();

        if (expected_outputs.size() != 0)
            report_mismatch($sformatf("%0d outputs never arrived", expected_outputs.size()));
        $display("%0d sample items sent, %0d outputs checked, %0d register settings",
                 items_sent, results_checked, settings_count);
        $display("modes: clamps, separation, windup to saturation, bursts and hold-off");
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
